// ----- sv/gshp_pkg.sv -----
// ----------------------------------------------------------------------------
// gshp_pkg: shared types and constants of the slot handle pool
// Widths, request codes, table entry layout and controller interface structs.
// ----------------------------------------------------------------------------
package gshp_pkg;

   localparam int SLOT_COUNT = 1024;
   localparam int IDX_W      = 10;
   localparam int KEY_W      = 11;
   localparam int CNT_W      = 11;
   localparam int TAG_W      = 16;
   localparam int CBITS_W    = 4;
   localparam int REQ_W      = 4;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CBITS_W-1:0] CBITS_MAX = 4'd10;
   localparam logic [CNT_W-1:0]   CAP_MAX   = 11'd1024;
   localparam logic [IDX_W-1:0]   IDX_LAST  = 10'd1023;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ALLOC       = 4'd0;
   localparam logic [REQ_W-1:0] REQ_FREE_SLOT   = 4'd1;
   localparam logic [REQ_W-1:0] REQ_FREE_HANDLE = 4'd2;
   localparam logic [REQ_W-1:0] REQ_CHECK       = 4'd3;
   localparam logic [REQ_W-1:0] REQ_QUERY       = 4'd4;
   localparam logic [REQ_W-1:0] REQ_FIRST       = 4'd5;
   localparam logic [REQ_W-1:0] REQ_LAST        = 4'd6;
   localparam logic [REQ_W-1:0] REQ_NEXT        = 4'd7;
   localparam logic [REQ_W-1:0] REQ_PREV        = 4'd8;
   localparam logic [REQ_W-1:0] REQ_CLEAR       = 4'd9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY_BITS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_TAG      = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] link;
   } slot_entry_type;

   typedef enum logic [1:0] {
      SCAN_DOWN,
      SCAN_UP,
      SCAN_NEXT,
      SCAN_PREV
   } scan_mode_type;

   typedef enum logic [2:0] {
      ST_CLR_INIT,
      ST_CLR_REQ,
      ST_IDLE,
      ST_LOOK,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_CK,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic exec;
      logic scan_rd;
      logic scan_step;
      logic clr_step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic exec_clear;
      logic go_scan;
      logic scan_stop;
      logic clr_last;
      logic out_free;
      logic cap_write;
   } ctrl_status_type;

endpackage

// ----- sv/gshp_ctrl.sv -----
// ----------------------------------------------------------------------------
// gshp_ctrl: request sequencer
// Steps each transaction through lookup, execute, table walk or clear sweep, and result.
// ----------------------------------------------------------------------------
module gshp_ctrl import gshp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type st,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR_INIT: if (st.clr_last) state_in = ST_IDLE;
         ST_CLR_REQ:  if (st.clr_last) state_in = ST_DONE;
         ST_IDLE:     if (req_valid) state_in = ST_LOOK;
         ST_LOOK:     state_in = ST_EXEC;
         ST_EXEC: begin
            if (st.exec_clear)   state_in = ST_CLR_REQ;
            else if (st.go_scan) state_in = ST_SCAN_RD;
            else                 state_in = ST_DONE;
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CK;
         ST_SCAN_CK:  state_in = st.scan_stop ? ST_DONE : ST_SCAN_RD;
         ST_DONE:     if (st.out_free) state_in = ST_IDLE;
         default:     state_in = ST_CLR_INIT;
      endcase
      // capacity change restarts the table sweep
      if (st.cap_write) state_in = ST_CLR_INIT;
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLR_INIT,
         ST_CLR_REQ:  cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         ST_LOOK:     cmd = '0;
         ST_EXEC:     cmd.exec = 1'b1;
         ST_SCAN_RD:  cmd.scan_rd = 1'b1;
         ST_SCAN_CK:  cmd.scan_step = 1'b1;
         ST_DONE:     cmd.emit = st.out_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> state_ff == ST_IDLE && !req_stall)
      else $error("request taken outside idle");
   a_take_look: assert property (@(posedge clock) disable iff (reset)
      cmd.take && !st.cap_write |=> state_ff == ST_LOOK)
      else $error("lookup did not follow accept");
   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && !st.cap_write |=> state_ff == ST_IDLE)
      else $error("no return to idle after result");

endmodule

// ----- sv/gshp_dp.sv -----
// ----------------------------------------------------------------------------
// gshp_dp: slot table and pool datapath
// Slot memory, free list head, bounds, key counter, walk pointer, result regs.
// ----------------------------------------------------------------------------
module gshp_dp import gshp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output ctrl_status_type      st,
   input  logic [REQ_W-1:0]     req_type,
   input  logic [IDX_W-1:0]     req_slot_index,
   input  logic [KEY_W-1:0]     req_handle_key,
   input  logic [TAG_W-1:0]     req_handle_tag,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TAG_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [IDX_W-1:0]     rsp_result_index,
   output logic [KEY_W-1:0]     rsp_result_key,
   output logic [CNT_W-1:0]     rsp_live_count
);

   slot_entry_type slot_mem_ff [SLOT_COUNT];
   slot_entry_type mem_q_ff;

   logic [CBITS_W-1:0] cap_bits_ff, cap_bits_in;
   logic [TAG_W-1:0]   pool_tag_ff, pool_tag_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [KEY_W-1:0]   key_ctr_ff, key_ctr_in;
   logic [CNT_W-1:0]   free_head_ff, free_head_in;
   logic [IDX_W-1:0]   upper_ff, upper_in;
   logic [IDX_W-1:0]   lower_ff, lower_in;
   logic [IDX_W-1:0]   walk_ff, walk_in;
   scan_mode_type      mode_ff, mode_in;
   logic               up_pend_ff, up_pend_in;
   logic [IDX_W-1:0]   clr_ptr_ff, clr_ptr_in;
   logic [REQ_W-1:0]   rq_type_ff, rq_type_in;
   logic [IDX_W-1:0]   rq_idx_ff, rq_idx_in;
   logic [KEY_W-1:0]   rq_key_ff, rq_key_in;
   logic [TAG_W-1:0]   rq_tag_ff, rq_tag_in;
   logic               res_found_ff, res_found_in;
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;
   logic [KEY_W-1:0]   res_key_ff, res_key_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]   capacity;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   slot_entry_type     mem_wd;
   logic [IDX_W-1:0]   look_addr;
   logic [IDX_W-1:0]   rd_addr;
   logic               idx_ok, used_hit, handle_ok, hit, free_ok, dn_need, up_need;
   logic [CNT_W-1:0]   next_idx, walk_nx;
   logic [IDX_W-1:0]   bound;
   logic               go_scan, scan_stop, cap_write;

   assign capacity = (cap_bits_ff >= CBITS_MAX) ? CAP_MAX : (CNT_W'(1) << cap_bits_ff);

   assign idx_ok    = {1'b0, rq_idx_ff} < capacity;
   assign used_hit  = idx_ok && mem_q_ff.key != '0;
   assign handle_ok = rq_tag_ff == pool_tag_ff && idx_ok && rq_key_ff != '0 &&
                      mem_q_ff.key == rq_key_ff;
   assign hit       = mem_q_ff.key != '0;
   assign next_idx  = {1'b0, rq_idx_ff} + 1'b1;
   assign walk_nx   = {1'b0, walk_ff} + 1'b1;
   assign bound     = (rq_type_ff == REQ_FIRST) ? lower_ff : upper_ff;
   assign free_ok   = (rq_type_ff == REQ_FREE_SLOT) ? used_hit : handle_ok;
   assign dn_need   = upper_ff == rq_idx_ff && rq_idx_ff != '0;
   assign up_need   = lower_ff == rq_idx_ff && next_idx < capacity;
   assign cap_write = csr_valid && csr_index == CSR_CAPACITY_BITS;

   always_comb begin
      case (rq_type_ff)
         REQ_ALLOC:            look_addr = free_head_ff[IDX_W-1:0];
         REQ_FIRST, REQ_LAST:  look_addr = bound;
         default:              look_addr = rq_idx_ff;
      endcase
   end

   assign rd_addr = cmd.scan_rd ? walk_ff : look_addr;

   always_comb begin
      cap_bits_in  = cap_bits_ff;
      pool_tag_in  = pool_tag_ff;
      used_in      = used_ff;
      key_ctr_in   = key_ctr_ff;
      free_head_in = free_head_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      walk_in      = walk_ff;
      mode_in      = mode_ff;
      up_pend_in   = up_pend_ff;
      clr_ptr_in   = clr_ptr_ff;
      rq_type_in   = rq_type_ff;
      rq_idx_in    = rq_idx_ff;
      rq_key_in    = rq_key_ff;
      rq_tag_in    = rq_tag_ff;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      res_key_in   = res_key_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_wa       = rq_idx_ff;
      mem_wd       = '{key: '0, link: free_head_ff};
      go_scan      = 1'b0;
      scan_stop    = 1'b0;

      if (cmd.take) begin
         rq_type_in = req_type;
         rq_idx_in  = req_slot_index;
         rq_key_in  = req_handle_key;
         rq_tag_in  = req_handle_tag;
      end

      if (cmd.exec) begin
         res_found_in = 1'b0;
         res_idx_in   = '0;
         res_key_in   = '0;
         case (rq_type_ff)
            REQ_ALLOC: begin
               if (used_ff < capacity && free_head_ff < capacity) begin
                  mem_we       = 1'b1;
                  mem_wa       = free_head_ff[IDX_W-1:0];
                  mem_wd       = '{key: key_ctr_ff, link: mem_q_ff.link};
                  free_head_in = mem_q_ff.link;
                  res_found_in = 1'b1;
                  res_idx_in   = free_head_ff[IDX_W-1:0];
                  res_key_in   = key_ctr_ff;
                  used_in      = used_ff + 1'b1;
                  key_ctr_in   = (key_ctr_ff >= capacity) ? KEY_W'(1) : key_ctr_ff + 1'b1;
                  if (upper_ff < free_head_ff[IDX_W-1:0]) upper_in = free_head_ff[IDX_W-1:0];
                  if (lower_ff > free_head_ff[IDX_W-1:0]) lower_in = free_head_ff[IDX_W-1:0];
               end
            end
            REQ_FREE_SLOT, REQ_FREE_HANDLE: begin
               if (free_ok) begin
                  res_found_in = 1'b1;
                  res_idx_in   = rq_idx_ff;
                  res_key_in   = mem_q_ff.key;
                  mem_we       = 1'b1;
                  free_head_in = {1'b0, rq_idx_ff};
                  used_in      = used_ff - 1'b1;
                  up_pend_in   = dn_need && up_need;
                  if (dn_need) begin
                     go_scan = 1'b1;
                     mode_in = SCAN_DOWN;
                     walk_in = rq_idx_ff - 1'b1;
                  end else if (up_need) begin
                     go_scan = 1'b1;
                     mode_in = SCAN_UP;
                     walk_in = next_idx[IDX_W-1:0];
                  end
               end
            end
            REQ_CHECK: begin
               if (handle_ok) begin
                  res_found_in = 1'b1;
                  res_idx_in   = rq_idx_ff;
                  res_key_in   = rq_key_ff;
               end
            end
            REQ_QUERY: begin
               if (used_hit) begin
                  res_found_in = 1'b1;
                  res_idx_in   = rq_idx_ff;
                  res_key_in   = mem_q_ff.key;
               end
            end
            REQ_FIRST, REQ_LAST: begin
               if (used_ff != '0 && {1'b0, bound} < capacity && hit) begin
                  res_found_in = 1'b1;
                  res_idx_in   = bound;
                  res_key_in   = mem_q_ff.key;
               end
            end
            REQ_NEXT: begin
               if (used_hit && next_idx <= {1'b0, upper_ff} && next_idx < capacity) begin
                  go_scan = 1'b1;
                  mode_in = SCAN_NEXT;
                  walk_in = next_idx[IDX_W-1:0];
               end
            end
            REQ_PREV: begin
               if (used_hit && rq_idx_ff > lower_ff) begin
                  go_scan = 1'b1;
                  mode_in = SCAN_PREV;
                  walk_in = rq_idx_ff - 1'b1;
               end
            end
            REQ_CLEAR: begin
               res_found_in = 1'b1;
               used_in      = '0;
               key_ctr_in   = KEY_W'(1);
               upper_in     = '0;
               lower_in     = '0;
               free_head_in = '0;
               clr_ptr_in   = '0;
            end
            default: res_found_in = 1'b0;
         endcase
      end

      if (cmd.scan_step) begin
         case (mode_ff)
            SCAN_DOWN: begin
               upper_in = walk_ff;
               if (hit || walk_ff == '0) begin
                  if (up_pend_ff) begin
                     up_pend_in = 1'b0;
                     mode_in    = SCAN_UP;
                     walk_in    = next_idx[IDX_W-1:0];
                  end else begin
                     scan_stop = 1'b1;
                  end
               end else begin
                  walk_in = walk_ff - 1'b1;
               end
            end
            SCAN_UP: begin
               lower_in = walk_ff;
               if (hit || walk_nx >= capacity) scan_stop = 1'b1;
               else walk_in = walk_nx[IDX_W-1:0];
            end
            SCAN_NEXT: begin
               if (hit) begin
                  scan_stop    = 1'b1;
                  res_found_in = 1'b1;
                  res_idx_in   = walk_ff;
                  res_key_in   = mem_q_ff.key;
               end else if (walk_nx <= {1'b0, upper_ff} && walk_nx < capacity) begin
                  walk_in = walk_nx[IDX_W-1:0];
               end else begin
                  scan_stop = 1'b1;
               end
            end
            SCAN_PREV: begin
               if (hit) begin
                  scan_stop    = 1'b1;
                  res_found_in = 1'b1;
                  res_idx_in   = walk_ff;
                  res_key_in   = mem_q_ff.key;
               end else if (walk_ff > lower_ff) begin
                  walk_in = walk_ff - 1'b1;
               end else begin
                  scan_stop = 1'b1;
               end
            end
            default: scan_stop = 1'b1;
         endcase
      end

      if (cmd.clr_step) begin
         mem_we     = 1'b1;
         mem_wa     = clr_ptr_ff;
         mem_wd     = '{key: '0, link: {1'b0, clr_ptr_ff} + 1'b1};
         clr_ptr_in = clr_ptr_ff + 1'b1;
      end

      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (csr_valid && csr_index == CSR_POOL_TAG) pool_tag_in = csr_wdata;
      if (cap_write) begin
         cap_bits_in  = csr_wdata[CBITS_W-1:0];
         used_in      = '0;
         key_ctr_in   = KEY_W'(1);
         upper_in     = '0;
         lower_in     = '0;
         free_head_in = '0;
         clr_ptr_in   = '0;
      end
   end

   always_comb begin
      st.exec_clear = rq_type_ff == REQ_CLEAR;
      st.go_scan    = go_scan;
      st.scan_stop  = scan_stop;
      st.clr_last   = clr_ptr_ff == IDX_LAST;
      st.out_free   = !rsp_valid_ff || !rsp_stall;
      st.cap_write  = cap_write;
   end

   always_ff @(posedge clock) begin
      if (mem_we) slot_mem_ff[mem_wa] <= mem_wd;
      mem_q_ff <= slot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_bits_ff  <= CBITS_MAX;
         pool_tag_ff  <= TAG_W'(1);
         used_ff      <= '0;
         key_ctr_ff   <= KEY_W'(1);
         free_head_ff <= '0;
         upper_ff     <= '0;
         lower_ff     <= '0;
         clr_ptr_ff   <= '0;
         up_pend_ff   <= 1'b0;
         mode_ff      <= SCAN_DOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_bits_ff  <= cap_bits_in;
         pool_tag_ff  <= pool_tag_in;
         used_ff      <= used_in;
         key_ctr_ff   <= key_ctr_in;
         free_head_ff <= free_head_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         clr_ptr_ff   <= clr_ptr_in;
         up_pend_ff   <= up_pend_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff      <= walk_in;
      rq_type_ff   <= rq_type_in;
      rq_idx_ff    <= rq_idx_in;
      rq_key_ff    <= rq_key_in;
      rq_tag_ff    <= rq_tag_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      res_key_ff   <= res_key_in;
      if (cmd.emit) begin
         rsp_found        <= res_found_ff;
         rsp_result_index <= res_idx_ff;
         rsp_result_key   <= res_key_ff;
         rsp_live_count   <= used_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_used_cap: assert property (@(posedge clock) disable iff (reset)
      used_ff <= capacity)
      else $error("live count above capacity");
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      {1'b0, upper_ff} < capacity && {1'b0, lower_ff} < capacity)
      else $error("used bound outside capacity");
   a_key_ctr: assert property (@(posedge clock) disable iff (reset)
      key_ctr_ff != '0 && key_ctr_ff <= capacity)
      else $error("key counter out of range");

endmodule

// ----- sv/generational_slot_handle_pool_unit.sv -----
// ----------------------------------------------------------------------------
// generational_slot_handle_pool_unit: generational slot handle allocator
// Hands out slot handles (tag, key, index) from an in-table free list.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one request per transaction (alloc, free by slot or handle,
//    check, query, first, last, next, prev, clear); accepted when req_valid
//    is high and req_stall low. Exactly one rsp_* transaction per request.
//  - csr_* writes capacity_bits (index 0, also clears the pool) or pool_tag
//    (index 1); csr_ready is always high.
//  - Requests are handled one at a time. Table access goes through a single
//    registered-read slot memory, so a plain request goes through lookup,
//    execute and done before its result is registered; the block is idle
//    again as the result becomes valid. Frees at a used bound, next and prev
//    walk the table, reading and then checking each slot visited. Clear
//    sweeps all 1024 slots, one a cycle.
//  - After reset (and after a capacity write) a clearing pass over all 1024
//    slots runs with req_stall high before the first request is taken.
//  - The result sits in an output register; a stalled rsp side holds it while
//    the next request is already accepted and worked on.
// ----------------------------------------------------------------------------
module generational_slot_handle_pool_unit import gshp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [REQ_W-1:0]     req_type,
   input  logic [IDX_W-1:0]     req_slot_index,
   input  logic [KEY_W-1:0]     req_handle_key,
   input  logic [TAG_W-1:0]     req_handle_tag,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [IDX_W-1:0]     rsp_result_index,
   output logic [KEY_W-1:0]     rsp_result_key,
   output logic [CNT_W-1:0]     rsp_live_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TAG_W-1:0]     csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type st;

   // register writes never wait
   assign csr_ready = 1'b1;

   gshp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   gshp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_type         (req_type),
      .req_slot_index   (req_slot_index),
      .req_handle_key   (req_handle_key),
      .req_handle_tag   (req_handle_tag),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_result_index (rsp_result_index),
      .rsp_result_key   (rsp_result_key),
      .rsp_live_count   (rsp_live_count)
   );

endmodule

// ----- dv/generational_slot_handle_pool_unit_tb.sv -----
// ----------------------------------------------------------------------------
// generational_slot_handle_pool_unit_tb: self-checking bench for the slot pool
// Drives directed and random requests with random gaps and output stalls,
// predicts every response with a behavioral pool model and compares fields.
// ----------------------------------------------------------------------------
module generational_slot_handle_pool_unit_tb;
   import gshp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int REQ_TYPE_W = REQ_W;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [REQ_W-1:0]     req_type;
   logic [IDX_W-1:0]     req_slot_index;
   logic [KEY_W-1:0]     req_handle_key;
   logic [TAG_W-1:0]     req_handle_tag;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_found;
   logic [IDX_W-1:0]     rsp_result_index;
   logic [KEY_W-1:0]     rsp_result_key;
   logic [CNT_W-1:0]     rsp_live_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TAG_W-1:0]     csr_wdata;

   generational_slot_handle_pool_unit i_dut (.*);

   // clock, period 20
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // one predicted response transaction
   typedef struct {
      logic             found;
      logic [IDX_W-1:0] index;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] live;
   } pool_reply_type;

   pool_reply_type expected_replies[$];

   // ------------------------------------------------------------------------
   // Pool model: keys and free-list links per slot, bounds, live count.
   // ------------------------------------------------------------------------
   logic [KEY_W-1:0] mdl_key  [SLOT_COUNT];
   logic [CNT_W-1:0] mdl_link [SLOT_COUNT];
   int unsigned      mdl_live, mdl_next_key, mdl_free_head, mdl_upper, mdl_lower;
   int unsigned      mdl_cbits;
   logic [TAG_W-1:0] mdl_tag;

   int error_count = 0;
   int accepted_count = 0;
   int reply_count = 0;
   int found_count = 0;
   int idle_cycles = 0;
   bit long_hold = 0;
   int unsigned hold_len = 0;

   function automatic int unsigned pool_capacity();
      int unsigned c;
      c = 1 << mdl_cbits;
      return (c > SLOT_COUNT) ? SLOT_COUNT : c;
   endfunction

   function automatic bit slot_in_use(int unsigned i);
      return i < pool_capacity() && mdl_key[i] != 0;
   endfunction

   function automatic void pool_clear();
      mdl_live = 0;
      mdl_next_key = 1;
      mdl_upper = 0;
      mdl_lower = 0;
      mdl_free_head = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         mdl_key[i]  = '0;
         mdl_link[i] = CNT_W'(i + 1);
      end
   endfunction

   // release a slot and walk the bounds inward if it sat on one
   function automatic void pool_release(int unsigned idx);
      int unsigned cap;
      cap = pool_capacity();
      mdl_key[idx] = '0;
      mdl_link[idx] = CNT_W'(mdl_free_head);
      mdl_free_head = idx;
      mdl_live--;
      if (mdl_upper == idx)
         for (int unsigned i = idx; i > 0; i--) begin
            mdl_upper = i - 1;
            if (mdl_key[i-1] != 0) break;
         end
      if (mdl_lower == idx)
         for (int unsigned i = idx + 1; i < cap; i++) begin
            mdl_lower = i;
            if (mdl_key[i] != 0) break;
         end
   endfunction

   function automatic pool_reply_type pool_predict(logic [REQ_W-1:0] op,
         logic [IDX_W-1:0] sidx, logic [KEY_W-1:0] hkey, logic [TAG_W-1:0] htag);
      pool_reply_type r;
      int unsigned cap, a, b;
      bit handle_ok;
      cap = pool_capacity();
      r.found = 0; r.index = '0; r.key = '0;
      handle_ok = htag == mdl_tag && sidx < cap && hkey != 0 &&
                  mdl_key[(sidx < cap) ? sidx : 0] == hkey;
      case (op)
         REQ_ALLOC: begin
            if (mdl_live < cap && mdl_free_head < cap) begin
               a = mdl_free_head;
               mdl_free_head = mdl_link[a];
               mdl_key[a] = KEY_W'(mdl_next_key);
               r.found = 1; r.index = IDX_W'(a); r.key = KEY_W'(mdl_next_key);
               mdl_live++;
               mdl_next_key++;
               if (mdl_next_key > cap) mdl_next_key = 1;
               if (mdl_upper < a) mdl_upper = a;
               if (mdl_lower > a) mdl_lower = a;
            end
         end
         REQ_FREE_SLOT, REQ_FREE_HANDLE: begin
            if ((op == REQ_FREE_SLOT) ? slot_in_use(sidx) : handle_ok) begin
               r.found = 1; r.index = sidx; r.key = mdl_key[sidx];
               pool_release(sidx);
            end
         end
         REQ_CHECK: if (handle_ok) begin
            r.found = 1; r.index = sidx; r.key = hkey;
         end
         REQ_QUERY: if (slot_in_use(sidx)) begin
            r.found = 1; r.index = sidx; r.key = mdl_key[sidx];
         end
         REQ_FIRST, REQ_LAST: if (mdl_live != 0) begin
            b = (op == REQ_FIRST) ? mdl_lower : mdl_upper;
            if (slot_in_use(b)) begin
               r.found = 1; r.index = IDX_W'(b); r.key = mdl_key[b];
            end
         end
         REQ_NEXT: if (slot_in_use(sidx)) begin
            for (int unsigned i = sidx + 1; i <= mdl_upper && i < cap; i++)
               if (mdl_key[i] != 0) begin
                  r.found = 1; r.index = IDX_W'(i); r.key = mdl_key[i];
                  break;
               end
         end
         REQ_PREV: if (slot_in_use(sidx)) begin
            for (int unsigned i = sidx; i > mdl_lower; i--)
               if (mdl_key[i-1] != 0) begin
                  r.found = 1; r.index = IDX_W'(i - 1); r.key = mdl_key[i-1];
                  break;
               end
         end
         REQ_CLEAR: begin
            pool_clear();
            r.found = 1;
         end
         default: ;
      endcase
      r.live = CNT_W'(mdl_live);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Shared request driver: random or no gap, then hold valid until accepted.
   // Valid is low for at least the cycle after an accept; the block is busy
   // with the lookup then and never takes a request in that cycle.
   // ------------------------------------------------------------------------
   task automatic send_request(logic [REQ_W-1:0] op, logic [IDX_W-1:0] sidx,
         logic [KEY_W-1:0] hkey, logic [TAG_W-1:0] htag, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
      repeat (gap + 1) @(posedge clock);
      req_valid      <= 1'b1;
      req_type       <= op;
      req_slot_index <= sidx;
      req_handle_key <= hkey;
      req_handle_tag <= htag;
      do @(posedge clock); while (req_stall);
      // accepted at this edge: predict in order of acceptance
      expected_replies.push_back(pool_predict(op, sidx, hkey, htag));
      accepted_count++;
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_replies.size() != 0) @(posedge clock);
      // clears and bound walks end before their reply; the pause only adds idle time
      repeat (1100) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [TAG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_CAPACITY_BITS) begin
         mdl_cbits = data[CBITS_W-1:0];
         pool_clear();
      end else
         mdl_tag = data;
      // capacity writes start a fresh clearing pass; requests wait on stall
      @(posedge clock);
   endtask

   // try eight random slots for a live one, else pick any slot
   function automatic logic [IDX_W-1:0] pick_slot();
      int unsigned cap, s;
      cap = pool_capacity();
      for (int t = 0; t < 8; t++) begin
         s = $urandom_range(0, cap - 1);
         if (mdl_key[s] != 0) return IDX_W'(s);
      end
      return IDX_W'($urandom_range(0, 1023));
   endfunction

   task automatic random_request(bit mostly_alloc);
      logic [IDX_W-1:0] s;
      logic [KEY_W-1:0] k;
      logic [TAG_W-1:0] t;
      logic [REQ_W-1:0] op;
      int pick;
      s = pick_slot();
      k = mdl_key[s];
      t = mdl_tag;
      pick = $urandom_range(0, 99);
      if (mostly_alloc && pick < 45) op = REQ_ALLOC;
      else if (pick < 2) op = REQ_CLEAR;
      else if (pick < 4) op = REQ_TYPE_W'($urandom_range(10, 15));
      else op = REQ_TYPE_W'($urandom_range(0, 8));
      // broken handles now and then
      case ($urandom_range(0, 9))
         0: k = KEY_W'($urandom_range(0, 2047));
         1: t = TAG_W'($urandom);
         2: s = IDX_W'($urandom);
         default: ;
      endcase
      send_request(op, s, k, t);
   endtask

   // ------------------------------------------------------------------------
   // Response checker with random stalls; long hold when requested.
   // ------------------------------------------------------------------------
   initial begin
      pool_reply_type e;
      int stall_left;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            reply_count++;
            if (expected_replies.size() == 0) begin
               $error("unexpected response transaction");
               error_count++;
            end else begin
               e = expected_replies.pop_front();
               if (rsp_found !== e.found) begin
                  $error("found: expected %0d actual %0d", e.found, rsp_found);
                  error_count++;
               end
               if (rsp_result_index !== e.index) begin
                  $error("result_index: expected %0d actual %0d", e.index,
                         rsp_result_index);
                  error_count++;
               end
               if (rsp_result_key !== e.key) begin
                  $error("result_key: expected %0d actual %0d", e.key, rsp_result_key);
                  error_count++;
               end
               if (rsp_live_count !== e.live) begin
                  $error("live_count: expected %0d actual %0d", e.live, rsp_live_count);
                  error_count++;
               end
               if (e.found) found_count++;
            end
            stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
         end
         if (long_hold) begin
            hold_len++;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // watchdog: cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("generational_slot_handle_pool_unit_tb: errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_edges();
      // empty-pool queries, field extremes, unknown opcodes
      send_request(REQ_FIRST, '0, '0, '0);
      send_request(REQ_LAST, '0, '0, '0);
      send_request(REQ_QUERY, IDX_LAST, '0, '0);
      send_request(REQ_FREE_SLOT, '0, '0, '0);
      send_request(4'd15, IDX_LAST, 11'h7ff, 16'hffff);
      send_request(4'd10, '0, '0, '0);
      for (int i = 0; i < 5; i++) send_request(REQ_ALLOC, '0, '0, '0);
      send_request(REQ_CHECK, 10'd2, 11'd3, mdl_tag);
      send_request(REQ_CHECK, 10'd2, 11'd3, 16'hffff);      // tag mismatch
      send_request(REQ_CHECK, 10'd2, 11'd0, mdl_tag);       // zero key
      send_request(REQ_FREE_HANDLE, 10'd1, 11'd2, mdl_tag);
      send_request(REQ_NEXT, 10'd0, '0, '0);
      send_request(REQ_PREV, 10'd2, '0, '0);
      send_request(REQ_FREE_SLOT, 10'd0, '0, '0);           // lower bound walk
      send_request(REQ_FREE_SLOT, 10'd4, '0, '0);           // upper bound walk
      send_request(REQ_FIRST, '0, '0, '0);
      send_request(REQ_LAST, '0, '0, '0);
      send_request(REQ_FREE_SLOT, 10'd2, '0, '0);
      send_request(REQ_FREE_SLOT, 10'd3, '0, '0);           // pool emptied
      send_request(REQ_ALLOC, '0, '0, '0);
      send_request(REQ_CLEAR, IDX_LAST, 11'h400, 16'hffff);
      wait_drained();
   endtask

   task automatic test_small_pool_full();
      // capacity 2^0 and 2^2: fill, overflow, key wrap, beyond-capacity slots
      write_csr(CSR_CAPACITY_BITS, 16'd0);
      write_csr(CSR_POOL_TAG, 16'hffff);
      for (int i = 0; i < 3; i++) send_request(REQ_ALLOC, '0, '0, '0);
      send_request(REQ_QUERY, 10'd1, '0, '0);
      wait_drained();
      write_csr(CSR_CAPACITY_BITS, 16'd2);
      for (int i = 0; i < 60; i++) random_request(1);
      wait_drained();
   endtask

   task automatic test_random_configs();
      int unsigned cb_choice[6] = '{1, 3, 4, 10, 15, 6};
      foreach (cb_choice[c]) begin
         write_csr(CSR_CAPACITY_BITS, 16'(cb_choice[c]));
         write_csr(CSR_POOL_TAG, (c == 0) ? 16'd1 : 16'($urandom_range(1, 65535)));
         for (int i = 0; i < 120; i++) random_request(1);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      // receiver holds off for a long stretch while requests keep coming
      write_csr(CSR_CAPACITY_BITS, 16'd3);
      fork
         begin
            long_hold = 1;
            wait (hold_len >= 300);
            long_hold = 0;
         end
         for (int i = 0; i < 20; i++) send_request(REQ_ALLOC, '0, '0, '0, 1);
      join
      wait_drained();
      // random requests, with a pause midway until every reply is back
      for (int i = 0; i < 60; i++) begin
         random_request(1);
         if (i == 30) while (expected_replies.size() != 0) @(posedge clock);
      end
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = '0;
      req_slot_index = '0;
      req_handle_key = '0;
      req_handle_tag = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mdl_cbits = CBITS_MAX;
      mdl_tag = 16'd1;
      pool_clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_edges();
      test_small_pool_full();
      test_random_configs();
      test_backpressure();
      $display("covered %0d requests, %0d responses (%0d found) over capacities 1..1024",
               accepted_count, reply_count, found_count);
      if (error_count == 0)
         $display("generational_slot_handle_pool_unit_tb: clean");
      else
         $display("generational_slot_handle_pool_unit_tb: errors");
      $finish;
   end

endmodule
